// ----- rtl/spit_pkg.sv -----
`timescale 1ns / 1ps

package spit_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int ROW_W    = 9;
    localparam int PAIR_W   = 128;

    typedef enum logic [3:0] {
        REQ_INSERT    = 4'd0,
        REQ_MODIFY    = 4'd1,
        REQ_REMOVE    = 4'd2,
        REQ_FIND      = 4'd3,
        REQ_LOWER     = 4'd4,
        REQ_UPPER     = 4'd5,
        REQ_FIRST     = 4'd6,
        REQ_LAST      = 4'd7,
        REQ_POP_FIRST = 4'd8,
        REQ_POP_LAST  = 4'd9
    } req_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SRCH_END,
        ST_FETCH_RD,
        ST_FETCH_WAIT,
        ST_SHIFT_RD,
        ST_SHIFT_LOOP,
        ST_PUT,
        ST_ERASE_END,
        ST_DONE
    } state_t;

    function automatic logic [63:0] ordered_bits(input logic [63:0] v);
        return v[63] ? ~v : (v | 64'h8000_0000_0000_0000);
    endfunction

    // a sorts strictly below b
    function automatic logic pair_lt(input logic mode,
                                     input logic [63:0] ka, input logic [63:0] va,
                                     input logic [63:0] kb, input logic [63:0] vb);
        logic [63:0] ma;
        logic [63:0] mb;
        ma = ordered_bits(va);
        mb = ordered_bits(vb);
        if (mode) begin
            return (ma != mb) ? (ma < mb) : (ka < kb);
        end
        return (ka != kb) ? (ka < kb) : (ma < mb);
    endfunction

endpackage

// ----- rtl/spit_ram.sv -----
`timescale 1ns / 1ps

module spit_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/sorted_pair_index_table.sv -----
`timescale 1ns / 1ps

// Ordered table of up to 256 unique (key, value) pairs held sorted in one
// single-port-read, single-port-write RAM with a registered read port. One
// request is worked at a time. A find, lower, upper, insert, remove or
// modify starts with a binary search, and an insert, remove or pop then
// moves every pair behind the position at one RAM access per cycle; a modify
// does a remove, a second search and an insert. Values are double bit
// patterns ordered by their ordered-integer mapping; NaN is not supported.
// Writing order_mode empties the table. A result beat may wait on m_ready
// while the next request is already being worked.
module sorted_pair_index_table
    import spit_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_order_mode,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [3:0]       s_req_type,
    input  logic [63:0]      s_key,
    input  logic [63:0]      s_value,
    input  logic [63:0]      s_new_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [63:0]      m_key_out,
    output logic [63:0]      m_value_out,
    output logic [ROW_W-1:0] m_occupancy
);

    state_t state_reg, state_next;

    logic             mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [3:0]       req_reg;
    logic [63:0]      key_reg, value_reg, nv_reg;
    logic             phase2_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg, pos_reg;
    logic             found_reg;
    logic [CNT_W-1:0] src_reg, last_reg, n_reg;
    logic             up_reg;
    logic [1:0]       status_reg;
    logic [63:0]      ko_reg, vo_reg;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [63:0]      m_key_reg, m_value_reg;
    logic [ROW_W-1:0] m_row_reg;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [PAIR_W-1:0] wr_data, rd_data;

    logic [CNT_W-1:0] mid;
    logic [63:0]      probe_v;
    logic [63:0]      ent_k, ent_v;
    logic             ent_lt, ent_eq, go_right;
    logic             out_load;
    logic             is_upper;
    logic             ins_req;

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign probe_v  = phase2_reg ? nv_reg : value_reg;
    assign ent_k    = rd_data[PAIR_W-1:64];
    assign ent_v    = rd_data[63:0];
    assign ent_lt   = pair_lt(mode_reg, ent_k, ent_v, key_reg, probe_v);
    assign ent_eq   = (ent_k == key_reg) && (ent_v == probe_v);
    assign is_upper = (req_reg == REQ_UPPER);
    assign go_right = is_upper ? (ent_lt | ent_eq) : ent_lt;
    assign out_load = !m_valid_reg || m_ready;
    assign ins_req  = (req_reg == REQ_INSERT) || (req_reg == REQ_MODIFY && phase2_reg);

    spit_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(PAIR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                priority if (req_reg <= REQ_UPPER) begin
                    state_next = ST_SRCH_RD;
                end else if (req_reg <= REQ_POP_LAST && count_reg != '0) begin
                    state_next = ST_FETCH_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SRCH_RD: begin
                state_next = (lo_reg < hi_reg) ? ST_SRCH_CMP : ST_SRCH_END;
            end
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_SRCH_END: begin
                priority if (ins_req) begin
                    if (found_reg || count_reg >= CNT_W'(CAPACITY)) state_next = ST_DONE;
                    else if (count_reg == pos_reg) state_next = ST_PUT;
                    else state_next = ST_SHIFT_RD;
                end else if (req_reg == REQ_MODIFY || req_reg == REQ_REMOVE) begin
                    if (!found_reg) state_next = ST_DONE;
                    else if (count_reg - pos_reg == CNT_W'(1)) state_next = ST_ERASE_END;
                    else state_next = ST_SHIFT_RD;
                end else if (req_reg == REQ_FIND) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = (pos_reg < count_reg) ? ST_FETCH_RD : ST_DONE;
                end
            end
            ST_FETCH_RD: state_next = ST_FETCH_WAIT;
            ST_FETCH_WAIT: begin
                priority if (req_reg != REQ_POP_FIRST && req_reg != REQ_POP_LAST) begin
                    state_next = ST_DONE;
                end else if (count_reg - pos_reg == CNT_W'(1)) begin
                    state_next = ST_ERASE_END;
                end else begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: state_next = ST_SHIFT_LOOP;
            ST_SHIFT_LOOP: begin
                if (n_reg == '0) state_next = up_reg ? ST_PUT : ST_ERASE_END;
            end
            ST_PUT: state_next = ST_DONE;
            ST_ERASE_END: begin
                state_next = (req_reg == REQ_MODIFY && !phase2_reg) ? ST_SRCH_RD : ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ram and handshake controls
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = {key_reg, probe_v};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cfg_ready = 1'b1;
            end
            ST_SRCH_RD: begin
                rd_en   = (lo_reg < hi_reg);
                rd_addr = mid[ADDR_W-1:0];
            end
            ST_FETCH_RD: begin
                rd_en   = 1'b1;
                rd_addr = pos_reg[ADDR_W-1:0];
            end
            ST_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = src_reg[ADDR_W-1:0];
            end
            ST_SHIFT_LOOP: begin
                wr_en   = 1'b1;
                wr_addr = up_reg ? (last_reg[ADDR_W-1:0] + ADDR_W'(1))
                                 : (last_reg[ADDR_W-1:0] - ADDR_W'(1));
                wr_data = rd_data;
                rd_en   = (n_reg != '0);
                rd_addr = src_reg[ADDR_W-1:0];
            end
            ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            count_reg  <= '0;
            phase2_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        mode_reg  <= cfg_order_mode;
                        count_reg <= '0;
                    end
                    if (s_valid) begin
                        req_reg    <= s_req_type;
                        key_reg    <= s_key;
                        value_reg  <= s_value;
                        nv_reg     <= s_new_value;
                        phase2_reg <= 1'b0;
                    end
                end
                ST_DISPATCH: begin
                    status_reg <= STAT_MISS;
                    ko_reg     <= '0;
                    vo_reg     <= '0;
                    lo_reg     <= '0;
                    hi_reg     <= count_reg;
                    found_reg  <= 1'b0;
                    pos_reg    <= (req_reg == REQ_FIRST || req_reg == REQ_POP_FIRST)
                                  ? '0 : count_reg - CNT_W'(1);
                end
                ST_SRCH_RD: begin
                    if (lo_reg >= hi_reg) pos_reg <= lo_reg;
                    else last_reg <= mid;
                end
                ST_SRCH_CMP: begin
                    if (ent_eq) found_reg <= 1'b1;
                    if (go_right) lo_reg <= last_reg + CNT_W'(1);
                    else hi_reg <= last_reg;
                end
                ST_SRCH_END: begin
                    priority if (ins_req) begin
                        if (found_reg) status_reg <= STAT_MISS;
                        else if (count_reg >= CNT_W'(CAPACITY)) status_reg <= STAT_FULL;
                        up_reg  <= 1'b1;
                        src_reg <= count_reg - CNT_W'(1);
                        n_reg   <= count_reg - pos_reg;
                    end else if (req_reg == REQ_FIND) begin
                        status_reg <= found_reg ? STAT_OK : STAT_MISS;
                    end else begin
                        up_reg  <= 1'b0;
                        src_reg <= pos_reg + CNT_W'(1);
                        n_reg   <= count_reg - pos_reg - CNT_W'(1);
                    end
                end
                ST_FETCH_WAIT: begin
                    ko_reg     <= ent_k;
                    vo_reg     <= ent_v;
                    status_reg <= STAT_OK;
                    up_reg     <= 1'b0;
                    src_reg    <= pos_reg + CNT_W'(1);
                    n_reg      <= count_reg - pos_reg - CNT_W'(1);
                end
                ST_SHIFT_RD, ST_SHIFT_LOOP: begin
                    if (state_reg == ST_SHIFT_RD || n_reg != '0) begin
                        last_reg <= src_reg;
                        src_reg  <= up_reg ? src_reg - CNT_W'(1) : src_reg + CNT_W'(1);
                        n_reg    <= n_reg - CNT_W'(1);
                    end
                end
                ST_PUT: begin
                    count_reg  <= count_reg + CNT_W'(1);
                    status_reg <= STAT_OK;
                end
                ST_ERASE_END: begin
                    count_reg  <= count_reg - CNT_W'(1);
                    status_reg <= STAT_OK;
                    if (req_reg == REQ_MODIFY && !phase2_reg) begin
                        phase2_reg <= 1'b1;
                        lo_reg     <= '0;
                        hi_reg     <= count_reg - CNT_W'(1);
                        found_reg  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && out_load) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= status_reg;
                m_key_reg    <= (status_reg == STAT_OK) ? ko_reg : '0;
                m_value_reg  <= (status_reg == STAT_OK) ? vo_reg : '0;
                m_row_reg    <= ROW_W'(count_reg);
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_key_out   = m_key_reg;
    assign m_value_out = m_value_reg;
    assign m_occupancy = m_row_reg;

endmodule

// ----- rtl/spit_checker.sv -----
`timescale 1ns / 1ps

module spit_checker
    import spit_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_status,
    input logic [63:0]      m_key_out,
    input logic [63:0]      m_value_out,
    input logic [ROW_W-1:0] m_occupancy
);

    // a result beat holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // one request in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_key_out == '0 && m_value_out == '0)
        else $error("failed request carries a pair");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_occupancy == ROW_W'(CAPACITY))
        else $error("full status with room left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STAT_OK || m_status == STAT_MISS || m_status == STAT_FULL)
        else $error("bad status code");

endmodule

bind sorted_pair_index_table spit_checker u_spit_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_key_out   (m_key_out),
    .m_value_out (m_value_out),
    .m_occupancy (m_occupancy)
);
